@@ rtl/ipmb_pkg.sv @@
package ipmb_pkg;

  // Register indexes on the configuration port
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] IDX_BLOCK_PAIRS  = 2'd0;
  localparam logic [CfgIdxW-1:0] IDX_COLUMN_COUNT = 2'd1;

  localparam int CfgDataW   = 18;
  localparam int BlkRegW    = 18;
  localparam int ColRegW    = 9;
  localparam logic [BlkRegW-1:0] BLOCK_PAIRS_RST  = 18'd131072;
  localparam logic [ColRegW-1:0] COLUMN_COUNT_RST = 9'd80;
  localparam int MinColumns = 10;

  localparam int SampleW = 8;
  localparam int SqW     = 17;
  localparam int MagW    = 9;
  localparam int ColOutW = 8;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // One finished bin, handed from the front end to the root unit
  typedef struct packed {
    logic [SqW-1:0]     peak_sq;
    logic [ColOutW-1:0] column;
    logic               last;
  } bin_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } back_state_e;

endpackage

@@ rtl/ipmb_cfg.sv @@
module ipmb_cfg #(
  parameter int MAX_COLUMNS     = 256,
  parameter int MAX_BLOCK_PAIRS = 131072,
  parameter int CNT_W           = 18,
  parameter int COL_W           = 9,
  parameter int NUM_W           = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ipmb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ipmb_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                busy_o,
  output logic [CNT_W-1:0]                    blk_len_o,
  output logic [CNT_W-1:0]                    bin_len_o
);

  localparam int IT_W = $clog2(NUM_W + 1);

  logic [ipmb_pkg::BlkRegW-1:0] blk_reg_q;
  logic [ipmb_pkg::ColRegW-1:0] col_reg_q;
  logic                         start_q, start_d;
  logic                         run_q;
  logic [IT_W-1:0]              iter_q;
  logic [COL_W-1:0]             rem_q;
  logic [COL_W-1:0]             dvs_q;
  logic [NUM_W-1:0]             quo_q;
  logic [CNT_W-1:0]             pend_blk_q;
  logic [CNT_W-1:0]             pend_bin_q;

  logic [CNT_W-1:0] pairs_c;
  logic [COL_W-1:0] cols_c;
  logic [NUM_W-1:0] num_c;
  logic [COL_W:0]   trial;
  logic             ge;
  logic [COL_W:0]   rem_full;
  logic [NUM_W-1:0] quo_d;
  logic             wr_known;

  assign cfg_ready_o = 1'b1;
  assign wr_known = cfg_valid_i &&
                    (cfg_index_i == ipmb_pkg::IDX_BLOCK_PAIRS ||
                     cfg_index_i == ipmb_pkg::IDX_COLUMN_COUNT);
  assign start_d = wr_known;

  always_comb begin
    if (blk_reg_q == '0) begin
      pairs_c = CNT_W'(1);
    end else if (32'(blk_reg_q) > MAX_BLOCK_PAIRS) begin
      pairs_c = CNT_W'(MAX_BLOCK_PAIRS);
    end else begin
      pairs_c = CNT_W'(blk_reg_q);
    end
    if (32'(col_reg_q) < ipmb_pkg::MinColumns) begin
      cols_c = COL_W'(ipmb_pkg::MinColumns);
    end else if (32'(col_reg_q) > MAX_COLUMNS) begin
      cols_c = COL_W'(MAX_COLUMNS);
    end else begin
      cols_c = COL_W'(col_reg_q);
    end
  end

  // ceil(pairs / cols) by restoring division, one quotient bit a cycle
  assign num_c    = NUM_W'(pairs_c) + NUM_W'(cols_c) - NUM_W'(1);
  assign trial    = {rem_q, quo_q[NUM_W-1]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign rem_full = ge ? trial - {1'b0, dvs_q} : trial;
  assign quo_d    = {quo_q[NUM_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_reg_q <= ipmb_pkg::BLOCK_PAIRS_RST;
      col_reg_q <= ipmb_pkg::COLUMN_COUNT_RST;
      start_q   <= 1'b1;
      run_q     <= 1'b0;
      iter_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == ipmb_pkg::IDX_BLOCK_PAIRS) begin
        blk_reg_q <= cfg_data_i[ipmb_pkg::BlkRegW-1:0];
      end
      if (cfg_valid_i && cfg_index_i == ipmb_pkg::IDX_COLUMN_COUNT) begin
        col_reg_q <= cfg_data_i[ipmb_pkg::ColRegW-1:0];
      end
      start_q <= start_d;
      if (start_q) begin
        run_q  <= 1'b1;
        iter_q <= IT_W'(NUM_W);
      end else if (run_q) begin
        iter_q <= iter_q - IT_W'(1);
        if (iter_q == IT_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      quo_q      <= num_c;
      rem_q      <= '0;
      dvs_q      <= cols_c;
      pend_blk_q <= pairs_c;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_full[COL_W-1:0];
      if (iter_q == IT_W'(1)) begin
        pend_bin_q <= CNT_W'(quo_d);
      end
    end
  end

  assign busy_o    = start_q || run_q;
  assign blk_len_o = pend_blk_q;
  assign bin_len_o = pend_bin_q;

endmodule

@@ rtl/ipmb_front.sv @@
module ipmb_front #(
  parameter int CNT_W  = 18,
  parameter int COLI_W = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ipmb_pkg::SampleW-1:0]      i_sample_i,
  input  logic [ipmb_pkg::SampleW-1:0]      q_sample_i,
  input  logic                              cfg_busy_i,
  input  logic [CNT_W-1:0]                  pend_blk_i,
  input  logic [CNT_W-1:0]                  pend_bin_i,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output ipmb_pkg::bin_rec_t                push_rec_o
);

  logic [CNT_W-1:0]         blk_len_q, bin_len_q;
  logic [CNT_W-1:0]         cnt_bin_q, cnt_blk_q;
  logic [COLI_W-1:0]        col_q;
  logic [ipmb_pkg::SqW-1:0] peak_q;

  logic signed [8:0]        di, dq;
  logic signed [17:0]       di2, dq2;
  logic [ipmb_pkg::SqW-1:0] sq, peak_new;
  logic [CNT_W-1:0]         eff_blk, eff_bin, cnt_bin_n, cnt_blk_n;
  logic                     accept, block_start, last_bin, emit;

  assign in_stall_o  = cfg_busy_i || fifo_full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign block_start = cnt_blk_q == '0;

  // 2x - 255 is {x, 1} with the top bit flipped, read as signed
  assign di  = {~i_sample_i[7], i_sample_i[6:0], 1'b1};
  assign dq  = {~q_sample_i[7], q_sample_i[6:0], 1'b1};
  assign di2 = di * di;
  assign dq2 = dq * dq;
  assign sq  = ipmb_pkg::SqW'(di2[15:0]) + ipmb_pkg::SqW'(dq2[15:0]);

  assign eff_blk   = block_start ? pend_blk_i : blk_len_q;
  assign eff_bin   = block_start ? pend_bin_i : bin_len_q;
  assign peak_new  = (cnt_bin_q == '0 || sq > peak_q) ? sq : peak_q;
  assign cnt_bin_n = cnt_bin_q + CNT_W'(1);
  assign cnt_blk_n = cnt_blk_q + CNT_W'(1);
  assign last_bin  = cnt_blk_n >= eff_blk;
  assign emit      = last_bin || cnt_bin_n >= eff_bin;

  assign push_o             = accept && emit;
  assign push_rec_o.peak_sq = peak_new;
  assign push_rec_o.column  = ipmb_pkg::ColOutW'(col_q);
  assign push_rec_o.last    = last_bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_bin_q <= '0;
      cnt_blk_q <= '0;
      col_q     <= '0;
      peak_q    <= '0;
    end else if (accept) begin
      if (emit) begin
        cnt_bin_q <= '0;
        peak_q    <= '0;
        if (last_bin) begin
          cnt_blk_q <= '0;
          col_q     <= '0;
        end else begin
          cnt_blk_q <= cnt_blk_n;
          col_q     <= col_q + COLI_W'(1);
        end
      end else begin
        cnt_bin_q <= cnt_bin_n;
        cnt_blk_q <= cnt_blk_n;
        peak_q    <= peak_new;
      end
    end
  end

  // Lengths are sampled at the first pair of each block
  always_ff @(posedge clk_i) begin
    if (accept && block_start) begin
      blk_len_q <= pend_blk_i;
      bin_len_q <= pend_bin_i;
    end
  end

endmodule

@@ rtl/ipmb_fifo.sv @@
module ipmb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ipmb_pkg::bin_rec_t  push_rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ipmb_pkg::bin_rec_t  pop_rec_o
);

  ipmb_pkg::bin_rec_t                   mem_q [ipmb_pkg::FifoDepth];
  logic [ipmb_pkg::FifoPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [ipmb_pkg::FifoCntW-1:0]        cnt_q;

  assign full_o    = cnt_q == ipmb_pkg::FifoCntW'(ipmb_pkg::FifoDepth);
  assign empty_o   = cnt_q == '0;
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + ipmb_pkg::FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + ipmb_pkg::FifoPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + ipmb_pkg::FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - ipmb_pkg::FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

@@ rtl/ipmb_back.sv @@
module ipmb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  ipmb_pkg::bin_rec_t            rec_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ipmb_pkg::MagW-1:0]     peak_magnitude_x2_o,
  output logic [ipmb_pkg::ColOutW-1:0]  column_index_o,
  output logic                          frame_last_o
);

  ipmb_pkg::back_state_e state_q, state_d;

  logic [ipmb_pkg::SqW-1:0]     v_q;
  logic [ipmb_pkg::SqW-1:0]     root_q;
  logic [ipmb_pkg::SqW-1:0]     bit_q;
  logic [ipmb_pkg::ColOutW-1:0] col_q;
  logic                         last_q;
  logic                         out_valid_q;
  logic [ipmb_pkg::MagW-1:0]    mag_q;
  logic [ipmb_pkg::ColOutW-1:0] out_col_q;
  logic                         out_last_q;

  logic [ipmb_pkg::SqW:0]       trial;
  logic                         take;
  logic                         load_out;

  // Digit-by-digit root, two radicand bits per step, nine steps
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = {1'b0, v_q} >= trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipmb_pkg::BK_IDLE: if (!empty_i) state_d = ipmb_pkg::BK_CALC;
      ipmb_pkg::BK_CALC: if (bit_q[0]) state_d = ipmb_pkg::BK_DONE;
      ipmb_pkg::BK_DONE: if (!out_valid_q || !out_stall_i) state_d = ipmb_pkg::BK_IDLE;
      default:           state_d = ipmb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ipmb_pkg::BK_IDLE: pop_o    = !empty_i;
      ipmb_pkg::BK_DONE: load_out = !out_valid_q || !out_stall_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipmb_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      v_q    <= rec_i.peak_sq;
      root_q <= '0;
      bit_q  <= ipmb_pkg::SqW'(1) << (ipmb_pkg::SqW - 1);
      col_q  <= rec_i.column;
      last_q <= rec_i.last;
    end else if (state_q == ipmb_pkg::BK_CALC) begin
      if (take) begin
        v_q    <= v_q - trial[ipmb_pkg::SqW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (load_out) begin
      mag_q      <= root_q[ipmb_pkg::MagW-1:0];
      out_col_q  <= col_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign peak_magnitude_x2_o = mag_q;
  assign column_index_o      = out_col_q;
  assign frame_last_o        = out_last_q;

endmodule

@@ rtl/iq_peak_magnitude_binner.sv @@
// IQ peak magnitude binner.
// Input channel: one unsigned I/Q byte pair per transfer (in_valid_i / in_stall_o).
// Output channel: one result per bin (out_valid_o / out_stall_i) carrying
// floor(2 * peak magnitude), the bin number and a last-bin-of-block flag.
// Config port: index 0 = block_pairs, index 1 = column_count; other indexes
// are ignored. New values apply from the next block start.
// Each write to either register starts a bin-length divide; the input stalls
// while it runs. The same divide runs right after reset, so the input is
// stalled until that first divide finishes.
// Throughput: the front end takes one pair per cycle unless the config divide
// or a full queue stalls the input. Each bin result passes through the queue
// handoff, the serial square-root unit and the output register load, and the
// root unit takes a new bin only when done with the last; a 4-entry queue
// absorbs bursts of short bins.
// When the receiver stalls the output register holds; the root unit, then the
// queue fill, and once the queue is full the input channel stalls.
module iq_peak_magnitude_binner #(
  parameter int MAX_COLUMNS     = 256,
  parameter int MAX_BLOCK_PAIRS = 131072
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ipmb_pkg::SampleW-1:0]        i_sample_i,
  input  logic [ipmb_pkg::SampleW-1:0]        q_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ipmb_pkg::MagW-1:0]           peak_magnitude_x2_o,
  output logic [ipmb_pkg::ColOutW-1:0]        column_index_o,
  output logic                                frame_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ipmb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ipmb_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int CNT_W  = $clog2(MAX_BLOCK_PAIRS + 1);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int COLI_W = $clog2(MAX_COLUMNS);
  localparam int NUM_W  = $clog2(MAX_BLOCK_PAIRS + MAX_COLUMNS);

  logic               cfg_busy;
  logic [CNT_W-1:0]   pend_blk, pend_bin;
  logic               fifo_full, fifo_empty, push, pop;
  ipmb_pkg::bin_rec_t push_rec, pop_rec;

  ipmb_cfg #(
    .MAX_COLUMNS     (MAX_COLUMNS),
    .MAX_BLOCK_PAIRS (MAX_BLOCK_PAIRS),
    .CNT_W           (CNT_W),
    .COL_W           (COL_W),
    .NUM_W           (NUM_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (cfg_busy),
    .blk_len_o   (pend_blk),
    .bin_len_o   (pend_bin)
  );

  ipmb_front #(
    .CNT_W  (CNT_W),
    .COLI_W (COLI_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .i_sample_i  (i_sample_i),
    .q_sample_i  (q_sample_i),
    .cfg_busy_i  (cfg_busy),
    .pend_blk_i  (pend_blk),
    .pend_bin_i  (pend_bin),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_rec_o  (push_rec)
  );

  ipmb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .empty_o    (fifo_empty),
    .pop_rec_o  (pop_rec)
  );

  ipmb_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .empty_i             (fifo_empty),
    .rec_i               (pop_rec),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .peak_magnitude_x2_o (peak_magnitude_x2_o),
    .column_index_o      (column_index_o),
    .frame_last_o        (frame_last_o)
  );

endmodule

@@ rtl/ipmb_checker.sv @@
module ipmb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ipmb_pkg::MagW-1:0]           peak_magnitude_x2_o,
  input logic [ipmb_pkg::ColOutW-1:0]        column_index_o,
  input logic                                frame_last_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [ipmb_pkg::CfgIdxW-1:0]        cfg_index_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(peak_magnitude_x2_o) && $stable(column_index_o) && $stable(frame_last_o))
    else $error("result payload changed while stalled");

  // The floor of twice the magnitude of a centered byte pair never exceeds 360
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_magnitude_x2_o <= 9'd360)
    else $error("magnitude out of range");

  // A register write restarts the bin-length divide, which holds off input
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
      (cfg_index_i == ipmb_pkg::IDX_BLOCK_PAIRS ||
       cfg_index_i == ipmb_pkg::IDX_COLUMN_COUNT)
      |=> in_stall_o)
    else $error("input taken during bin-length update");

  // Input is held off in the cycle after reset while the divide starts
  a_rst_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open before bin length is ready");

endmodule

bind iq_peak_magnitude_binner ipmb_checker u_ipmb_checker (.*);
